/* design/ptc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers of the pressure/temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CALIB_WORDS = 11;
  localparam int unsigned CAL_IDX_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // calibration word positions
  localparam int unsigned CAL_AC1 = 0;
  localparam int unsigned CAL_AC2 = 1;
  localparam int unsigned CAL_AC3 = 2;
  localparam int unsigned CAL_AC4 = 3;
  localparam int unsigned CAL_AC5 = 4;
  localparam int unsigned CAL_AC6 = 5;
  localparam int unsigned CAL_B1  = 6;
  localparam int unsigned CAL_B2  = 7;
  localparam int unsigned CAL_MB  = 8;
  localparam int unsigned CAL_MC  = 9;
  localparam int unsigned CAL_MD  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OSS = 1'b0,
    CFG_ALT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CAL  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef logic [CALIB_WORDS-1:0][15:0] calib_t;

  // one conversion in flight, with its intermediate values
  typedef struct packed {
    logic        vld;
    logic        inval;
    logic        dz;
    logic        neg;
    logic [15:0] ut;
    logic [31:0] up;
    calib_t      cal;
    logic [31:0] m1;
    logic [31:0] x1;
    logic [31:0] dv;
    logic [31:0] b5;
    logic [31:0] t;
    logic [31:0] b6;
    logic [31:0] sqm;
    logic [31:0] ma2;
    logic [31:0] ma3;
    logic [31:0] sq;
    logic [31:0] x2a;
    logic [31:0] x1c;
    logic [31:0] mb1;
    logic [31:0] mb2;
    logic [31:0] x3;
    logic [31:0] x3c;
    logic [31:0] b3;
    logic [31:0] x3b;
    logic [31:0] b4m;
    logic [31:0] b4;
    logic [31:0] b7;
    logic [31:0] p;
    logic [31:0] pq;
    logic [31:0] mp;
    logic [31:0] qq;
    logic [31:0] x2p;
    logic [31:0] x1m;
    logic [31:0] p2;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

  localparam logic [31:0] T_OFS      = 32'd4000;
  localparam logic [31:0] P_C1       = 32'd3038;
  localparam logic [31:0] P_C2       = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3       = 32'd3791;
  localparam logic [31:0] B7_BASE    = 32'd50000;
  localparam logic [31:0] B4_OFS     = 32'd32768;
  // reciprocal of 83 for 17-bit values, scaled by 2^22
  localparam logic [15:0] RECIP_83   = 16'd50534;
  localparam int unsigned RECIP_SH   = 22;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = a + bias;
    return 32'($signed(sum) >>> k);
  endfunction

endpackage

/* design/ptc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// Unsigned 32-bit restoring divider, one quotient bit per pipeline stage,
// with a sideband word that travels alongside.
// ----------------------------------------------------------------------------
module ptc_div #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [31:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [31:0]       quot_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int unsigned STAGES = 32;

  logic [32:0]       rem_q  [STAGES];
  logic [31:0]       num_q  [STAGES];
  logic [31:0]       quo_q  [STAGES];
  logic [31:0]       dsr_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [32:0]       rem_in;
    logic [31:0]       num_in;
    logic [31:0]       quo_in;
    logic [31:0]       dsr_in;
    logic [SIDE_W-1:0] side_in;
    logic [32:0]       rem_sh;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = dividend_i;
      assign quo_in  = '0;
      assign dsr_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign dsr_in  = dsr_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rem_sh = {rem_in[31:0], num_in[31]};
    assign ge     = (rem_sh >= {1'b0, dsr_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? (rem_sh - {1'b0, dsr_in}) : rem_sh;
        num_q[s] <= {num_in[30:0], 1'b0};
        quo_q[s] <= {quo_in[30:0], ge};
        dsr_q[s] <= dsr_in;
      end
    end
  end

  assign quot_o = quo_q[STAGES-1];
  assign side_o = side_q[STAGES-1];

endmodule

/* design/ptc_calib.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_calib
// Calibration word table with write port and validity check.
// ----------------------------------------------------------------------------
module ptc_calib (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ptc_pkg::CAL_IDX_W-1:0]    idx_i,
  input  logic [15:0]                      word_i,
  output ptc_pkg::calib_t                  cal_o,
  output logic                             inval_o
);
  import ptc_pkg::*;

  calib_t tbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else if (we_i && (idx_i < CAL_IDX_W'(CALIB_WORDS))) begin
      tbl_q[idx_i] <= word_i;
    end
  end

  // all-zero or all-one words mark an unprogrammed device
  always_comb begin
    inval_o = 1'b0;
    for (int i = 0; i < CALIB_WORDS; i++) begin
      if (tbl_q[i] == 16'h0000 || tbl_q[i] == 16'hFFFF) begin
        inval_o = 1'b1;
      end
    end
  end

  assign cal_o = tbl_q;

endmodule

/* design/pressure_temperature_compensation_unit.sv */
`timescale 1ns / 1ps
// pipeline: 18 arithmetic stages plus two 32-stage dividers, one quotient bit per stage
// throughput: one word per cycle; a stalled output freezes the whole pipeline
// load words write the calibration table at acceptance and give no result
// reset clears the calibration table (invalid), oversampling to 3, altitude to 0
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Barometric sensor integer compensation pipeline.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [3:0]                       calib_index_i,
  input  logic [15:0]                      calib_word_i,
  input  logic [15:0]                      raw_temperature_i,
  input  logic [23:0]                      raw_pressure_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               temperature_tenths_o,
  output logic signed [31:0]               pressure_pa_o,
  output logic signed [31:0]               sea_level_pa_o,
  output logic [1:0]                       status_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ptc_pkg::*;

  logic        en;
  logic [1:0]  oss_q;
  logic [14:0] alt_q;
  calib_t      cal;
  logic        inval;

  logic [15:0] alt_mag_q;
  logic        alt_neg_q;
  logic [32:0] alt_rm_q;
  logic        alt_neg2_q;
  logic [15:0] alt_mag2_q;
  logic [31:0] corr_q;
  logic [31:0] corr_mag;

  item_t st1_d, st1_q, st2_d, st2_q, st3_d, st3_q, d1_side, d1_out;
  item_t st4_d, st4_q, st5_d, st5_q, st6_d, st6_q, st7_d, st7_q;
  item_t st8_d, st8_q, st9_d, st9_q, st10_d, st10_q, st11_d, st11_q;
  item_t st12_d, st12_q, d2_out, st13_d, st13_q, st14_d, st14_q;
  item_t st15_d, st15_q, st16_d, st16_q, st17_d, st17_q;
  logic [ITEM_W-1:0] d1_side_out, d2_side_out;
  logic [31:0] d1_num, d1_den, d1_quot, d2_num, d2_quot;

  logic        out_valid_q;
  logic [31:0] temp_q, pres_q, sea_q;
  logic [1:0]  status_q;

  assign en          = out_ready_i | ~out_valid_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q <= 2'd3;
      alt_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OSS: oss_q <= cfg_data_i[1:0];
        CFG_ALT: alt_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // altitude term (1000*alt)/83 = 12*|alt| + (4*|alt|)/83, sign applied last
  assign corr_mag = 32'(alt_mag2_q) * 32'd12 + 32'(alt_rm_q >> RECIP_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mag_q  <= '0;
      alt_neg_q  <= 1'b0;
      alt_rm_q   <= '0;
      alt_neg2_q <= 1'b0;
      alt_mag2_q <= '0;
      corr_q     <= '0;
    end else begin
      alt_neg_q  <= alt_q[14];
      alt_mag_q  <= alt_q[14] ? (16'd0 - {alt_q[14], alt_q}) : {1'b0, alt_q};
      alt_rm_q   <= 33'({alt_mag_q, 2'b00}) * 33'(RECIP_83);
      alt_neg2_q <= alt_neg_q;
      alt_mag2_q <= alt_mag_q;
      corr_q     <= alt_neg2_q ? (32'd0 - corr_mag) : corr_mag;
    end
  end

  // ---------------- calibration table ----------------
  ptc_calib u_calib (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_valid_i && en && (command_i == CMD_LOAD)),
    .idx_i   (calib_index_i),
    .word_i  (calib_word_i),
    .cal_o   (cal),
    .inval_o (inval)
  );

  // ---------------- front stages ----------------
  always_comb begin
    st1_d       = '0;
    st1_d.vld   = in_valid_i && (command_i == CMD_CONVERT);
    st1_d.inval = inval;
    st1_d.cal   = cal;
    st1_d.ut    = raw_temperature_i;
    st1_d.up    = 32'(raw_pressure_i) >> (4'd8 - {2'b00, oss_q});
  end

  always_comb begin
    st2_d    = st1_q;
    st2_d.m1 = (32'(st1_q.ut) - 32'(st1_q.cal[CAL_AC6])) * 32'(st1_q.cal[CAL_AC5]);
  end

  always_comb begin
    st3_d    = st2_q;
    st3_d.x1 = sdiv_p2(st2_q.m1, 15);
    st3_d.dv = st3_d.x1 + sx16(st2_q.cal[CAL_MD]);
    st3_d.dz = (st3_d.dv == 32'd0);
  end

  // x2 = (mc*2048)/(x1+md), signed through magnitudes
  always_comb begin
    logic [31:0] a;
    a           = sx16(st3_q.cal[CAL_MC]) << 11;
    d1_num      = a[31] ? (32'd0 - a) : a;
    d1_den      = st3_q.dv[31] ? (32'd0 - st3_q.dv) : st3_q.dv;
    d1_side     = st3_q;
    d1_side.neg = a[31] ^ st3_q.dv[31];
  end

  ptc_div #(.SIDE_W(ITEM_W)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .dividend_i (d1_num),
    .divisor_i  (d1_den),
    .side_i     (d1_side),
    .quot_o     (d1_quot),
    .side_o     (d1_side_out)
  );

  assign d1_out = item_t'(d1_side_out);

  // ---------------- middle stages ----------------
  always_comb begin
    st4_d    = d1_out;
    st4_d.b5 = d1_out.x1 + (d1_out.neg ? (32'd0 - d1_quot) : d1_quot);
  end

  always_comb begin
    st5_d    = st4_q;
    st5_d.t  = sdiv_p2(st4_q.b5 + 32'd8, 4);
    st5_d.b6 = st4_q.b5 - T_OFS;
  end

  always_comb begin
    st6_d     = st5_q;
    st6_d.sqm = st5_q.b6 * st5_q.b6;
    st6_d.ma2 = sx16(st5_q.cal[CAL_AC2]) * st5_q.b6;
    st6_d.ma3 = sx16(st5_q.cal[CAL_AC3]) * st5_q.b6;
  end

  always_comb begin
    st7_d     = st6_q;
    st7_d.sq  = sdiv_p2(st6_q.sqm, 12);
    st7_d.x2a = sdiv_p2(st6_q.ma2, 11);
    st7_d.x1c = sdiv_p2(st6_q.ma3, 13);
  end

  always_comb begin
    st8_d     = st7_q;
    st8_d.mb2 = sx16(st7_q.cal[CAL_B2]) * st7_q.sq;
    st8_d.mb1 = sx16(st7_q.cal[CAL_B1]) * st7_q.sq;
  end

  always_comb begin
    st9_d     = st8_q;
    st9_d.x3  = sdiv_p2(st8_q.mb2, 11) + st8_q.x2a;
    st9_d.x3c = st8_q.x1c + sdiv_p2(st8_q.mb1, 16) + 32'd2;
  end

  always_comb begin
    logic [31:0] s;
    s          = ((sx16(st9_q.cal[CAL_AC1]) << 2) + st9_q.x3) << oss_q;
    st10_d     = st9_q;
    st10_d.b3  = sdiv_p2(s + 32'd2, 2);
    st10_d.x3b = sdiv_p2(st9_q.x3c, 2);
  end

  always_comb begin
    st11_d     = st10_q;
    st11_d.b4m = 32'(st10_q.cal[CAL_AC4]) * (st10_q.x3b + B4_OFS);
    st11_d.b7  = (st10_q.up - st10_q.b3) * (B7_BASE >> oss_q);
  end

  always_comb begin
    st12_d    = st11_q;
    st12_d.b4 = st11_q.b4m >> 15;
    st12_d.dz = st11_q.dz | (st12_d.b4 == 32'd0);
  end

  // unsigned p = b7*2/b4, or (b7/b4)*2 when b7 has its top bit set
  assign d2_num = st12_q.b7[31] ? st12_q.b7 : {st12_q.b7[30:0], 1'b0};

  ptc_div #(.SIDE_W(ITEM_W)) u_div_p (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .dividend_i (d2_num),
    .divisor_i  (st12_q.b4),
    .side_i     (st12_q),
    .quot_o     (d2_quot),
    .side_o     (d2_side_out)
  );

  assign d2_out = item_t'(d2_side_out);

  // ---------------- back stages ----------------
  always_comb begin
    st13_d   = d2_out;
    st13_d.p = d2_out.b7[31] ? {d2_quot[30:0], 1'b0} : d2_quot;
  end

  always_comb begin
    st14_d    = st13_q;
    st14_d.pq = sdiv_p2(st13_q.p, 8);
    st14_d.mp = P_C2 * st13_q.p;
  end

  always_comb begin
    st15_d     = st14_q;
    st15_d.qq  = st14_q.pq * st14_q.pq;
    st15_d.x2p = sdiv_p2(st14_q.mp, 16);
  end

  always_comb begin
    st16_d     = st15_q;
    st16_d.x1m = st15_q.qq * P_C1;
  end

  always_comb begin
    st17_d    = st16_q;
    st17_d.p2 = st16_q.p
              + sdiv_p2(sdiv_p2(st16_q.x1m, 16) + st16_q.x2p + P_C3, 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q  <= '0;
      st2_q  <= '0;
      st3_q  <= '0;
      st4_q  <= '0;
      st5_q  <= '0;
      st6_q  <= '0;
      st7_q  <= '0;
      st8_q  <= '0;
      st9_q  <= '0;
      st10_q <= '0;
      st11_q <= '0;
      st12_q <= '0;
      st13_q <= '0;
      st14_q <= '0;
      st15_q <= '0;
      st16_q <= '0;
      st17_q <= '0;
    end else if (en) begin
      st1_q  <= st1_d;
      st2_q  <= st2_d;
      st3_q  <= st3_d;
      st4_q  <= st4_d;
      st5_q  <= st5_d;
      st6_q  <= st6_d;
      st7_q  <= st7_d;
      st8_q  <= st8_d;
      st9_q  <= st9_d;
      st10_q <= st10_d;
      st11_q <= st11_d;
      st12_q <= st12_d;
      st13_q <= st13_d;
      st14_q <= st14_d;
      st15_q <= st15_d;
      st16_q <= st16_d;
      st17_q <= st17_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= st17_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (st17_q.inval) begin
        status_q <= ST_CAL;
        temp_q   <= '0;
        pres_q   <= '0;
        sea_q    <= '0;
      end else if (st17_q.dz) begin
        status_q <= ST_DIV0;
        temp_q   <= '0;
        pres_q   <= '0;
        sea_q    <= '0;
      end else begin
        status_q <= ST_OK;
        temp_q   <= st17_q.t;
        pres_q   <= st17_q.p2;
        sea_q    <= st17_q.p2 + corr_q;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = temp_q;
  assign pressure_pa_o        = pres_q;
  assign sea_level_pa_o       = sea_q;
  assign status_o             = status_q;

endmodule

/* design/ptc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] temperature_tenths_o,
  input logic [31:0] pressure_pa_o,
  input logic [31:0] sea_level_pa_o,
  input logic [1:0]  status_o
);
  import ptc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pressure_pa_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CAL || status_o == ST_DIV0) |->
      temperature_tenths_o == 32'd0 && pressure_pa_o == 32'd0 &&
      sea_level_pa_o == 32'd0)
    else $error("error result carries nonzero values");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .temperature_tenths_o (temperature_tenths_o),
  .pressure_pa_o        (pressure_pa_o),
  .sea_level_pa_o       (sea_level_pa_o),
  .status_o             (status_o)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure/temperature compensation unit. A
// cycle-free model of the integer compensation predicts each conversion.
// Words are loaded and converted through valid/ready with random gaps and
// stalls, and the configuration is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import ptc_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  idx;
    logic [15:0] word;
    logic [15:0] ut;
    logic [23:0] up;
  } word_t;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] pres;
    logic [31:0] sea;
    logic [1:0]  status;
  } comp_t;

  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYC  = 100;

  // typical sensor calibration set
  localparam logic [15:0] TYP_CAL [CALIB_WORDS] = '{
    16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd32757, 16'd23153,
    16'd6190, 16'd4, 16'h8000, 16'hDDF9, 16'd2868
  };

  logic clk, rst_ni;
  logic in_valid, in_ready_o;
  logic command;
  logic [3:0] calib_index;
  logic [15:0] calib_word, raw_temperature;
  logic [23:0] raw_pressure;
  logic out_valid_o, out_ready;
  logic signed [31:0] temperature_tenths_o, pressure_pa_o, sea_level_pa_o;
  logic [1:0] status_o;
  logic cfg_valid, cfg_ready_o;
  cfg_idx_e cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  word_t word_q[$];
  comp_t comp_q[$];
  word_t cur_word;

  logic [15:0] cal_tab [CALIB_WORDS];
  logic [1:0]  osr;
  logic [14:0] alt_m;

  int  n_fail;
  int  tx_gap, rx_gap;
  int  hold_cnt;
  logic hold_go;
  logic quiet;
  int  wdog;

  pressure_temperature_compensation_unit DUT (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .command_i           (command),
    .calib_index_i       (calib_index),
    .calib_word_i        (calib_word),
    .raw_temperature_i   (raw_temperature),
    .raw_pressure_i      (raw_pressure),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .temperature_tenths_o(temperature_tenths_o),
    .pressure_pa_o       (pressure_pa_o),
    .sea_level_pa_o      (sea_level_pa_o),
    .status_o            (status_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // signed quotient, truncating toward zero; min / -1 wraps to min
  function automatic logic [31:0] quot32(input logic [31:0] a, input logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [31:0] cal_val(input int i);
    if (i == CAL_AC4 || i == CAL_AC5 || i == CAL_AC6) return {16'd0, cal_tab[i]};
    return {{16{cal_tab[i][15]}}, cal_tab[i]};
  endfunction

  function automatic comp_t compensate(input word_t w);
    comp_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, dv, b5, b6, sq, b3, b4, b7, p, qv, altv;
    r = '{temp: 0, pres: 0, sea: 0, status: ST_OK};
    foreach (cal_tab[i])
      if (cal_tab[i] == 16'h0000 || cal_tab[i] == 16'hFFFF) r.status = ST_CAL;
    if (r.status == ST_CAL) return r;
    ac1 = cal_val(CAL_AC1); ac2 = cal_val(CAL_AC2); ac3 = cal_val(CAL_AC3);
    ac4 = cal_val(CAL_AC4); ac5 = cal_val(CAL_AC5); ac6 = cal_val(CAL_AC6);
    b1 = cal_val(CAL_B1); b2 = cal_val(CAL_B2);
    mc = cal_val(CAL_MC); md = cal_val(CAL_MD);
    ut = {16'd0, w.ut};
    up = {8'd0, w.up} >> (8 - osr);
    x1 = quot32((ut - ac6) * ac5, 32'd32768);
    dv = x1 + md;
    if (dv == 32'd0) begin
      r.status = ST_DIV0;
      return r;
    end
    x2 = quot32(mc * 32'd2048, dv);
    b5 = x1 + x2;
    r.temp = quot32(b5 + 32'd8, 32'd16);
    b6 = b5 - 32'd4000;
    sq = quot32(b6 * b6, 32'd4096);
    x1 = quot32(b2 * sq, 32'd2048);
    x2 = quot32(ac2 * b6, 32'd2048);
    x3 = x1 + x2;
    b3 = quot32(((ac1 * 32'd4 + x3) << osr) + 32'd2, 32'd4);
    x1 = quot32(ac3 * b6, 32'd8192);
    x2 = quot32(b1 * sq, 32'd65536);
    x3 = quot32(x1 + x2 + 32'd2, 32'd4);
    b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
    if (b4 == 32'd0) begin
      r = '{temp: 0, pres: 0, sea: 0, status: ST_DIV0};
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> osr);
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    qv = quot32(p, 32'd256);
    x1 = quot32((qv * qv) * 32'd3038, 32'd65536);
    x2 = quot32((32'd0 - 32'd7357) * p, 32'd65536);
    p = p + quot32(x1 + x2 + 32'd3791, 32'd16);
    altv = {{17{alt_m[14]}}, alt_m};
    r.pres = p;
    r.sea = p + quot32(altv * 32'd1000, 32'd83);
    return r;
  endfunction

  // sender side
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      command <= CMD_LOAD;
      calib_index <= '0;
      calib_word <= '0;
      raw_temperature <= '0;
      raw_pressure <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (cur_word.cmd == CMD_CONVERT) comp_q.push_back(compensate(cur_word));
        else if (cur_word.idx < CALIB_WORDS) cal_tab[cur_word.idx] = cur_word.word;
      end
      if (!in_valid || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          tx_gap <= $urandom_range(1, 10);
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          command <= cur_word.cmd;
          calib_index <= cur_word.idx;
          calib_word <= cur_word.word;
          raw_temperature <= cur_word.ut;
          raw_pressure <= cur_word.up;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) hold_cnt <= 0;
    else if (hold_go) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver side and checker
  always @(posedge clk or negedge rst_ni) begin
    comp_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (comp_q.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, status_o);
          n_fail++;
        end else begin
          e = comp_q.pop_front();
          if (temperature_tenths_o !== e.temp) begin
            $display("%0t: temperature exp %0d got %0d", $time, $signed(e.temp),
                     temperature_tenths_o);
            n_fail++;
          end
          if (pressure_pa_o !== e.pres) begin
            $display("%0t: pressure exp %0d got %0d", $time, $signed(e.pres),
                     pressure_pa_o);
            n_fail++;
          end
          if (sea_level_pa_o !== e.sea) begin
            $display("%0t: sea level exp %0d got %0d", $time, $signed(e.sea),
                     sea_level_pa_o);
            n_fail++;
          end
          if (status_o !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, status_o);
            n_fail++;
          end
        end
      end
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_gap <= $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic add_load(input int i, input logic [15:0] w);
    word_t x;
    x = '{cmd: CMD_LOAD, idx: 4'(i), word: w, ut: 16'($urandom), up: 24'($urandom)};
    word_q.push_back(x);
  endtask

  task automatic add_conv(input logic [15:0] ut, input logic [23:0] up);
    word_t x;
    x = '{cmd: CMD_CONVERT, idx: 4'($urandom), word: 16'($urandom), ut: ut, up: up};
    word_q.push_back(x);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_OSS) osr = data[1:0];
    else alt_m = data[14:0];
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid || comp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // calibration near a typical part, now and then a fully random word
  task automatic load_random_cal();
    logic [15:0] w;
    for (int i = 0; i < CALIB_WORDS; i++) begin
      if ($urandom_range(0, 14) == 0) w = 16'($urandom);
      else w = TYP_CAL[i] + 16'($urandom_range(0, 200)) - 16'd100;
      add_load(i, w);
    end
  endtask

  task automatic add_random_words(input int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: add_load($urandom_range(0, 15), 16'($urandom));
        1: add_conv(16'($urandom), 24'($urandom));
        default: add_conv(16'($urandom_range(20000, 36000)),
                          {8'($urandom_range(0, 255)) >> 1 | 8'h40, 16'($urandom)});
      endcase
    end
  endtask

  initial begin
    logic [15:0] a;
    n_fail = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OSS;
    cfg_data = '0;
    foreach (cal_tab[i]) cal_tab[i] = 16'h0000;
    osr = 2'd3;
    alt_m = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;

    // empty table gives invalid calibration; out-of-range loads are dropped
    add_conv(16'd27898, 24'h5D2300);
    add_load(11, 16'd1234);
    add_load(15, 16'hFFFF);
    for (int i = 0; i < CALIB_WORDS; i++) add_load(i, TYP_CAL[i]);
    add_conv(16'd27898, 24'h5D2300);
    add_conv(16'h0000, 24'h000000);
    add_conv(16'hFFFF, 24'hFFFFFF);
    add_load(CAL_MB, 16'hFFFF);
    add_conv(16'd27898, 24'h5D2300);
    // zero temperature divisor: ac5 = 2^15 makes x1 = ut - ac6
    add_load(CAL_MB, TYP_CAL[CAL_MB]);
    add_load(CAL_AC5, 16'h8000);
    add_conv(TYP_CAL[CAL_AC6] - TYP_CAL[CAL_MD], 24'h5D2300);
    // zero b4: tiny ac4 with strongly negative x3
    add_load(CAL_AC4, 16'd1);
    add_load(CAL_AC3, 16'h8000);
    add_load(CAL_B1, 16'd1);
    add_load(CAL_AC6, 16'd1);
    add_load(CAL_MC, 16'd1);
    add_conv(16'd12001, 24'h5D2300);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_OSS, 16'd0);
          cfg_write(CFG_ALT, 16'h7C18);       // -1000
        end
        1: begin
          cfg_write(CFG_OSS, 16'd3);
          cfg_write(CFG_ALT, 16'h8000 | 16'd9000);
        end
        2: begin
          cfg_write(CFG_OSS, 16'd1);
          cfg_write(CFG_ALT, 16'd0);
        end
        3: begin
          cfg_write(CFG_OSS, 16'd2);
          a = 16'($urandom);
          cfg_write(CFG_ALT, a);
        end
        default: begin
          cfg_write(CFG_OSS, 16'($urandom));
          a = 16'($urandom_range(0, 10000)) - 16'd1000;
          cfg_write(CFG_ALT, a);
        end
      endcase
      if (ph == 5) quiet = 1'b1;
      load_random_cal();
      add_random_words(40);
      if (ph == 1) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (ph == 2) begin
        // sender waits for every pending result mid-phase
        while (word_q.size() != 0 || in_valid || comp_q.size() != 0) @(posedge clk);
      end
      add_random_words(40);
      wait_drained();
    end

    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* pressure_temperature_compensation_unit.f */
design/ptc_pkg.sv
design/ptc_div.sv
design/ptc_calib.sv
design/pressure_temperature_compensation_unit.sv
design/ptc_checker.sv
tb/sv/tb.sv
